// File: src/vbkr_pkg.sv
`default_nettype none
package vbkr_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [4:0] TYPE_KEY    = 5'd1;
  localparam logic [4:0] TYPE_SWITCH = 5'd5;

  localparam logic [9:0] CODE_MENU_KEY  = 10'd158;
  localparam logic [9:0] CODE_PLUS_KEY  = 10'd115;
  localparam logic [9:0] CODE_MINUS_KEY = 10'd114;
  localparam logic [9:0] CODE_JACK_SW   = 10'd2;

  localparam logic [7:0] VAL_RELEASE = 8'd0;
  localparam logic [7:0] VAL_REPEAT  = 8'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_GAP        = 3'd4;

  localparam logic [5:0]  RST_VOLUME_LIMIT     = 6'd20;
  localparam logic [5:0]  RST_BRIGHTNESS_LIMIT = 6'd10;
  localparam logic [15:0] RST_REPEAT_DELAY     = 16'd300;
  localparam logic [15:0] RST_REPEAT_INTERVAL  = 16'd100;
  localparam logic [15:0] RST_STALE_GAP        = 16'd1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] time_ms;
    logic [4:0]  event_type;
    logic [9:0]  event_code;
    logic [7:0]  event_value;
  } item_t;

  typedef struct packed {
    logic [5:0]  volume_limit;
    logic [5:0]  brightness_limit;
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_interval_ms;
    logic [15:0] stale_gap_ms;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/vbkr_cfg.sv
`default_nettype none
module vbkr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [vbkr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vbkr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output vbkr_pkg::cfg_t                        cfg
);
  import vbkr_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volume_limit       <= RST_VOLUME_LIMIT;
      cfg_r.brightness_limit   <= RST_BRIGHTNESS_LIMIT;
      cfg_r.repeat_delay_ms    <= RST_REPEAT_DELAY;
      cfg_r.repeat_interval_ms <= RST_REPEAT_INTERVAL;
      cfg_r.stale_gap_ms       <= RST_STALE_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOLUME_LIMIT:     cfg_r.volume_limit       <= cfg_wdata[5:0];
        CFG_BRIGHTNESS_LIMIT: cfg_r.brightness_limit   <= cfg_wdata[5:0];
        CFG_REPEAT_DELAY:     cfg_r.repeat_delay_ms    <= cfg_wdata;
        CFG_REPEAT_INTERVAL:  cfg_r.repeat_interval_ms <= cfg_wdata;
        CFG_STALE_GAP:        cfg_r.stale_gap_ms       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: src/vbkr_in_stage.sv
`default_nettype none
module vbkr_in_stage (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_time_ms,
  input  wire logic [4:0]  in_event_type,
  input  wire logic [9:0]  in_event_code,
  input  wire logic [7:0]  in_event_value,
  input  wire logic        take,
  output logic             item_valid,
  output vbkr_pkg::item_t  item
);
  import vbkr_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall  = valid_r & ~take;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.kind        <= in_kind;
      item_r.time_ms     <= in_time_ms;
      item_r.event_type  <= in_event_type;
      item_r.event_code  <= in_event_code;
      item_r.event_value <= in_event_value;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// File: src/vbkr_core.sv
`default_nettype none
module vbkr_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire vbkr_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  input  wire vbkr_pkg::item_t item,
  output logic                 take,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [5:0]           out_volume_level,
  output logic [5:0]           out_brightness_level,
  output logic                 out_jack_inserted,
  output logic                 out_volume_changed,
  output logic                 out_brightness_changed,
  output logic                 out_jack_changed
);
  import vbkr_pkg::*;

  logic [31:0] last_time_r, last_time_nxt;
  logic [31:0] frame_time_r, frame_time_nxt;
  logic        discard_r, discard_nxt;
  logic        menu_held_r, menu_held_nxt;
  logic        plus_held_r, plus_held_nxt;
  logic        plus_fresh_r, plus_fresh_nxt;
  logic [31:0] plus_due_r, plus_due_nxt;
  logic        minus_held_r, minus_held_nxt;
  logic        minus_fresh_r, minus_fresh_nxt;
  logic [31:0] minus_due_r, minus_due_nxt;
  logic [5:0]  vol_r, vol_nxt;
  logic [5:0]  bri_r, bri_nxt;
  logic        jack_r, jack_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        vol_chg_r, vol_chg_nxt;
  logic        bri_chg_r, bri_chg_nxt;
  logic        jack_chg_r, jack_chg_nxt;

  logic        cap;

  assign take          = ~out_valid_r | ~out_stall;
  assign cap           = item_valid & take;
  assign out_valid_nxt = cap | (out_valid_r & out_stall);

  always_comb begin : step_logic
    logic        on;
    logic        mh, ph, pf, mnh, mnf;
    logic [31:0] pdue, mdue;
    logic        plus_go, minus_go;
    logic [5:0]  vol_a, bri_a;

    on       = item.event_value != VAL_RELEASE;
    mh       = menu_held_r & ~discard_r;
    ph       = plus_held_r & ~discard_r;
    pf       = plus_fresh_r & ~discard_r;
    mnh      = minus_held_r & ~discard_r;
    mnf      = minus_fresh_r & ~discard_r;
    pdue     = discard_r ? 32'd0 : plus_due_r;
    mdue     = discard_r ? 32'd0 : minus_due_r;
    plus_go  = 1'b0;
    minus_go = 1'b0;
    vol_a    = vol_r;
    bri_a    = bri_r;

    last_time_nxt   = last_time_r;
    frame_time_nxt  = frame_time_r;
    discard_nxt     = discard_r;
    menu_held_nxt   = menu_held_r;
    plus_held_nxt   = plus_held_r;
    plus_fresh_nxt  = plus_fresh_r;
    plus_due_nxt    = plus_due_r;
    minus_held_nxt  = minus_held_r;
    minus_fresh_nxt = minus_fresh_r;
    minus_due_nxt   = minus_due_r;
    vol_nxt         = vol_r;
    bri_nxt         = bri_r;
    jack_nxt        = jack_r;
    vol_chg_nxt     = 1'b0;
    bri_chg_nxt     = 1'b0;
    jack_chg_nxt    = 1'b0;

    if (cap) begin
      unique case (item.kind)
        KIND_START: begin
          frame_time_nxt = item.time_ms;
          discard_nxt    = (item.time_ms - last_time_r) > {16'd0, cfg.stale_gap_ms};
        end
        KIND_EVENT: begin
          if (!discard_r) begin
            priority if (item.event_type == TYPE_SWITCH && item.event_code == CODE_JACK_SW) begin
              jack_nxt     = item.event_value != VAL_RELEASE;
              jack_chg_nxt = 1'b1;
            end else if (item.event_type == TYPE_KEY && item.event_value <= VAL_REPEAT) begin
              priority if (item.event_code == CODE_MENU_KEY) begin
                menu_held_nxt = on;
              end else if (item.event_code == CODE_PLUS_KEY) begin
                plus_held_nxt  = on;
                plus_fresh_nxt = on;
                if (on) plus_due_nxt = frame_time_r + {16'd0, cfg.repeat_delay_ms};
              end else if (item.event_code == CODE_MINUS_KEY) begin
                minus_held_nxt  = on;
                minus_fresh_nxt = on;
                if (on) minus_due_nxt = frame_time_r + {16'd0, cfg.repeat_delay_ms};
              end else begin
              end
            end else begin
            end
          end
        end
        KIND_END: begin
          // plus goes first; minus then sees the level plus left
          plus_go = pf | (ph & (frame_time_r >= pdue));
          if (plus_go) begin
            if (mh) begin
              if (bri_a < cfg.brightness_limit) begin
                bri_a       = bri_a + 6'd1;
                bri_chg_nxt = 1'b1;
              end
            end else if (vol_a < cfg.volume_limit) begin
              vol_a       = vol_a + 6'd1;
              vol_chg_nxt = 1'b1;
            end
            if (pf) pf = 1'b0;
            else pdue = pdue + {16'd0, cfg.repeat_interval_ms};
          end

          minus_go = mnf | (mnh & (frame_time_r >= mdue));
          if (minus_go) begin
            if (mh) begin
              if (bri_a != 6'd0) begin
                bri_a       = bri_a - 6'd1;
                bri_chg_nxt = 1'b1;
              end
            end else if (vol_a != 6'd0) begin
              vol_a       = vol_a - 6'd1;
              vol_chg_nxt = 1'b1;
            end
            if (mnf) mnf = 1'b0;
            else mdue = mdue + {16'd0, cfg.repeat_interval_ms};
          end

          menu_held_nxt   = mh;
          plus_held_nxt   = ph;
          plus_fresh_nxt  = pf;
          plus_due_nxt    = pdue;
          minus_held_nxt  = mnh;
          minus_fresh_nxt = mnf;
          minus_due_nxt   = mdue;
          vol_nxt         = vol_a;
          bri_nxt         = bri_a;
          last_time_nxt   = frame_time_r;
          discard_nxt     = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r   <= 32'd0;
      frame_time_r  <= 32'd0;
      discard_r     <= 1'b0;
      menu_held_r   <= 1'b0;
      plus_held_r   <= 1'b0;
      plus_fresh_r  <= 1'b0;
      plus_due_r    <= 32'd0;
      minus_held_r  <= 1'b0;
      minus_fresh_r <= 1'b0;
      minus_due_r   <= 32'd0;
      vol_r         <= 6'd0;
      bri_r         <= 6'd0;
      jack_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      last_time_r   <= last_time_nxt;
      frame_time_r  <= frame_time_nxt;
      discard_r     <= discard_nxt;
      menu_held_r   <= menu_held_nxt;
      plus_held_r   <= plus_held_nxt;
      plus_fresh_r  <= plus_fresh_nxt;
      plus_due_r    <= plus_due_nxt;
      minus_held_r  <= minus_held_nxt;
      minus_fresh_r <= minus_fresh_nxt;
      minus_due_r   <= minus_due_nxt;
      vol_r         <= vol_nxt;
      bri_r         <= bri_nxt;
      jack_r        <= jack_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // change flags only move with a captured request
  always_ff @(posedge clk) begin
    if (cap) begin
      vol_chg_r  <= vol_chg_nxt;
      bri_chg_r  <= bri_chg_nxt;
      jack_chg_r <= jack_chg_nxt;
    end
  end

  // levels are only updated on capture, so the state doubles as result payload
  assign out_valid              = out_valid_r;
  assign out_volume_level       = vol_r;
  assign out_brightness_level   = bri_r;
  assign out_jack_inserted      = jack_r;
  assign out_volume_changed     = vol_chg_r;
  assign out_brightness_changed = bri_chg_r;
  assign out_jack_changed       = jack_chg_r;

  a_one_level_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(vol_chg_r && bri_chg_r) && !(jack_chg_r && (vol_chg_r || bri_chg_r)))
    else $error("more than one change flag set");

  // an up and a down step in one frame end can leave the level where it was
  a_vol_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cap |=> (vol_r == $past(vol_r)) || vol_chg_r)
    else $error("volume moved without its flag");

  a_bri_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cap |=> (bri_r == $past(bri_r)) || bri_chg_r)
    else $error("brightness moved without its flag");

  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cap |=> $stable(vol_r) && $stable(bri_r) && $stable(jack_r))
    else $error("levels moved without a request");

endmodule
`default_nettype wire

// File: src/volume_brightness_key_repeat.sv
`default_nettype none
// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------------
// in       | in_kind .. in_event_value      | in_valid / in_stall
// out      | out_volume_level .. out_jack_* | out_valid / out_stall
// cfg      | cfg_index, cfg_wdata           | cfg_we, no wait
//
// One request per cycle sustained while out_stall is low; a request passes through
// the input register, then the state and result register, before its result is presented.
// Synchronous active-low reset restores register defaults and zero state.
// out_stall backs up into in_stall in the same cycle once the input
// register is also full.
module volume_brightness_key_repeat (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [31:0]                     in_time_ms,
  input  wire logic [4:0]                      in_event_type,
  input  wire logic [9:0]                      in_event_code,
  input  wire logic [7:0]                      in_event_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [5:0]                           out_volume_level,
  output logic [5:0]                           out_brightness_level,
  output logic                                 out_jack_inserted,
  output logic                                 out_volume_changed,
  output logic                                 out_brightness_changed,
  output logic                                 out_jack_changed,
  input  wire logic                            cfg_we,
  input  wire logic [vbkr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vbkr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vbkr_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  take;

  vbkr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vbkr_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_time_ms     (in_time_ms),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .take           (take),
    .item_valid     (item_valid),
    .item           (item)
  );

  vbkr_core u_core (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .item_valid             (item_valid),
    .item                   (item),
    .take                   (take),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_volume_level       (out_volume_level),
    .out_brightness_level   (out_brightness_level),
    .out_jack_inserted      (out_jack_inserted),
    .out_volume_changed     (out_volume_changed),
    .out_brightness_changed (out_brightness_changed),
    .out_jack_changed       (out_jack_changed)
  );

endmodule
`default_nettype wire
